// File: src/bft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bft_pkg;

	localparam int HASH_W        = 45;
	localparam int ID_W          = 27;
	localparam int ROW_SHIFT     = 21;
	localparam int S_DATA_W      = 72;
	localparam int M_DATA_W      = 32;
	localparam int ROW_BITS_DEF  = 10;
	localparam int ROW_SLOTS_DEF = 16;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: src/bucketed_fingerprint_table.sv
// bucketed fingerprint table: lookup or insert of a 45-bit hash per word
// slave side: s_tuser is the operation (0 lookup, 1 insert), s_tdata holds
// the hash and the id to store; one word is taken at a time, s_tready is high
// only while the sequencer is idle
// master side: m_tdata holds the id of the first match and the ok flag
// the hash bits from 21 up pick a row, the remaining bits form the stored tag
// an insert reads the fill counter, then writes the slot and the counter, then
// passes its result on; a lookup reads the fill counter, then compares the
// slots of the row up to the first hit or the end of the row; the slot memory
// read port compares one slot per cycle
// reset starts a clearing pass over the 2**ROW_BITS row fill counters, one
// row per cycle; s_tready stays low until it ends
// a result waits in the output register while m_tready is low; the next word
// is still taken, and the sequencer holds its result until the register frees
`timescale 1ns / 1ps
`default_nettype none

module bucketed_fingerprint_table #(
	parameter int ROW_BITS  = bft_pkg::ROW_BITS_DEF,
	parameter int ROW_SLOTS = bft_pkg::ROW_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [bft_pkg::S_DATA_W-1:0] s_tdata,  // hash, id
	input  wire logic                         s_tuser,  // mode
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [bft_pkg::M_DATA_W-1:0] m_tdata   // found_id, ok, zero pad
);

	localparam int HASH_W    = bft_pkg::HASH_W;
	localparam int ID_W      = bft_pkg::ID_W;
	localparam int ROW_SHIFT = bft_pkg::ROW_SHIFT;
	localparam int SLOT_BITS = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
	localparam int FILL_W    = $clog2(ROW_SLOTS + 1);
	localparam int TAG_W     = HASH_W - ROW_BITS;
	localparam int ENTRY_W   = TAG_W + ID_W;
	localparam int SLOT_AW   = ROW_BITS + SLOT_BITS;
	localparam int PAD_W     = bft_pkg::M_DATA_W - ID_W - 1;

	bft_pkg::state_t state_q, state_d;

	logic [ROW_BITS-1:0]  clr_q;
	logic                 mode_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [TAG_W-1:0]     tag_q;
	logic [ID_W-1:0]      id_q;
	logic [FILL_W-1:0]    fill_q;
	logic [SLOT_BITS-1:0] k_q;
	logic [ID_W-1:0]      res_id_q;
	logic                 res_ok_q;
	logic [ID_W-1:0]      out_id_q;
	logic                 out_ok_q;
	logic                 out_valid_q;

	logic [HASH_W-1:0]    in_hash;
	logic [ID_W-1:0]      in_id;
	logic [ROW_BITS-1:0]  in_row;
	logic [HASH_W-1:0]    in_hi;
	logic [HASH_W-1:0]    in_tag_full;
	logic                 accept;
	logic                 out_free;

	logic                 fill_we;
	logic [ROW_BITS-1:0]  fill_waddr;
	logic [FILL_W-1:0]    fill_wdata;
	logic [ROW_BITS-1:0]  fill_raddr;
	logic [FILL_W-1:0]    fill_rd;

	logic                 slot_we;
	logic [SLOT_AW-1:0]   slot_waddr;
	logic [ENTRY_W-1:0]   slot_wdata;
	logic [SLOT_AW-1:0]   slot_raddr;
	logic [ENTRY_W-1:0]   slot_rd;

	logic                 has_room;
	logic                 hit;
	logic                 last;
	logic [SLOT_BITS-1:0] k_nx;

	assign in_hash     = s_tdata[HASH_W-1:0];
	assign in_id       = s_tdata[HASH_W +: ID_W];
	assign in_row      = in_hash[ROW_SHIFT +: ROW_BITS];
	assign in_hi       = in_hash >> (ROW_SHIFT + ROW_BITS);
	assign in_tag_full = {in_hi[HASH_W-ROW_SHIFT-1:0], in_hash[ROW_SHIFT-1:0]};

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign has_room = fill_rd < FILL_W'(ROW_SLOTS);
	assign hit      = slot_rd[ENTRY_W-1:ID_W] == tag_q;
	assign last     = (FILL_W'(k_q) + FILL_W'(1)) == fill_q;
	assign k_nx     = k_q + SLOT_BITS'(1);

	bft_ram #(
		.WIDTH (FILL_W),
		.ADDR_W(ROW_BITS)
	) u_fill_ram (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_waddr),
		.wdata(fill_wdata),
		.raddr(fill_raddr),
		.rdata(fill_rd)
	);

	bft_ram #(
		.WIDTH (ENTRY_W),
		.ADDR_W(SLOT_AW)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_raddr),
		.rdata(slot_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bft_pkg::ST_CLEAR: begin
				if (clr_q == {ROW_BITS{1'b1}}) begin
					state_d = bft_pkg::ST_IDLE;
				end
			end
			bft_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = bft_pkg::ST_FILL;
				end
			end
			bft_pkg::ST_FILL: begin
				if (mode_q == bft_pkg::MODE_INSERT || fill_rd == '0) begin
					state_d = bft_pkg::ST_DONE;
				end else begin
					state_d = bft_pkg::ST_SCAN;
				end
			end
			bft_pkg::ST_SCAN: begin
				if (hit || last) begin
					state_d = bft_pkg::ST_DONE;
				end
			end
			bft_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = bft_pkg::ST_IDLE;
				end
			end
			default: state_d = bft_pkg::ST_CLEAR;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		s_tready   = 1'b0;
		fill_we    = 1'b0;
		fill_waddr = row_q;
		fill_wdata = fill_rd + FILL_W'(1);
		fill_raddr = row_q;
		slot_we    = 1'b0;
		slot_waddr = {row_q, fill_rd[SLOT_BITS-1:0]};
		slot_wdata = {tag_q, id_q};
		slot_raddr = {row_q, k_nx};
		unique case (state_q)
			bft_pkg::ST_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
			end
			bft_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				fill_raddr = in_row;
			end
			bft_pkg::ST_FILL: begin
				slot_raddr = {row_q, {SLOT_BITS{1'b0}}};
				if (mode_q == bft_pkg::MODE_INSERT && has_room) begin
					fill_we = 1'b1;
					slot_we = 1'b1;
				end
			end
			bft_pkg::ST_SCAN: begin
			end
			bft_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bft_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bft_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ROW_BITS'(1);
			end
			if (state_q == bft_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// word payload and scan registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			row_q  <= in_row;
			tag_q  <= in_tag_full[TAG_W-1:0];
			id_q   <= in_id;
		end
		if (state_q == bft_pkg::ST_FILL) begin
			fill_q   <= fill_rd;
			k_q      <= '0;
			res_id_q <= '0;
			res_ok_q <= (mode_q == bft_pkg::MODE_INSERT) && has_room;
		end
		if (state_q == bft_pkg::ST_SCAN) begin
			k_q <= k_nx;
			if (hit) begin
				res_id_q <= slot_rd[ID_W-1:0];
				res_ok_q <= 1'b1;
			end
		end
		if (state_q == bft_pkg::ST_DONE && out_free) begin
			out_id_q <= res_id_q;
			out_ok_q <= res_ok_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_ok_q, out_id_q};

endmodule

`default_nettype wire

// File: src/bft_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bft_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: bench/bft_checker.sv
`timescale 1ns / 1ps

module bft_checker #(
	parameter int ROW_BITS  = bft_pkg::ROW_BITS_DEF,
	parameter int ROW_SLOTS = bft_pkg::ROW_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	input  wire logic                         s_tready,
	input  wire logic [bft_pkg::S_DATA_W-1:0] s_tdata,  // hash, id
	input  wire logic                         s_tuser,  // mode
	input  wire logic                         m_tvalid,
	input  wire logic                         m_tready,
	input  wire logic [bft_pkg::M_DATA_W-1:0] m_tdata,  // found_id, ok, zero pad
	output int                                errors,
	output int                                pending,
	output int                                hits,
	output int                                full_rejects
);

	localparam int HASH_W    = bft_pkg::HASH_W;
	localparam int ID_W      = bft_pkg::ID_W;
	localparam int ROW_SHIFT = bft_pkg::ROW_SHIFT;
	localparam int ROWS      = 1 << ROW_BITS;
	localparam int TAG_W     = HASH_W - ROW_BITS;

	typedef struct packed {
		logic [ID_W-1:0] found_id;
		logic            ok;
	} answer_t;

	int unsigned     fill_count [ROWS];
	logic [TAG_W-1:0] slot_tag  [ROWS * ROW_SLOTS];
	logic [ID_W-1:0]  slot_id   [ROWS * ROW_SLOTS];
	answer_t          due_answers[$];

	function automatic answer_t table_access(logic mode, logic [HASH_W-1:0] hash,
			logic [ID_W-1:0] id);
		int unsigned       row;
		int unsigned       base;
		logic [HASH_W-1:0] wide;
		logic [TAG_W-1:0]  tag;
		answer_t           a;
		row  = int'((hash >> ROW_SHIFT) & HASH_W'(ROWS - 1));
		base = row * ROW_SLOTS;
		wide = ((hash >> (ROW_SHIFT + ROW_BITS)) << ROW_SHIFT)
			| (hash & ((45'd1 << ROW_SHIFT) - 45'd1));
		tag  = wide[TAG_W-1:0];
		a    = '0;
		if (mode == bft_pkg::MODE_LOOKUP) begin
			for (int k = 0; k < fill_count[row]; k++) begin
				if (slot_tag[base + k] == tag) begin
					a.found_id = slot_id[base + k];
					a.ok       = 1'b1;
					break;
				end
			end
		end else if (fill_count[row] < ROW_SLOTS) begin
			slot_tag[base + fill_count[row]] = tag;
			slot_id[base + fill_count[row]]  = id;
			fill_count[row]++;
			a.ok = 1'b1;
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			foreach (fill_count[i])
				fill_count[i] = 0;
			due_answers.delete();
			errors       = 0;
			pending      = 0;
			hits         = 0;
			full_rejects = 0;
		end else begin
			// result side first: a word accepted now cannot have answered yet
			if (m_tvalid && m_tready) begin
				got.found_id = m_tdata[ID_W-1:0];
				got.ok       = m_tdata[ID_W];
				if (due_answers.size() == 0) begin
					$error("result word with nothing expected: found_id %0d ok %0d",
						got.found_id, got.ok);
					errors++;
				end else begin
					want = due_answers.pop_front();
					if (got.found_id !== want.found_id) begin
						$error("found_id: expected %0d, got %0d", want.found_id, got.found_id);
						errors++;
					end
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = table_access(s_tuser, s_tdata[HASH_W-1:0],
					s_tdata[HASH_W +: ID_W]);
				due_answers.push_back(want);
				if (s_tuser == bft_pkg::MODE_LOOKUP && want.ok)
					hits++;
				if (s_tuser == bft_pkg::MODE_INSERT && !want.ok)
					full_rejects++;
			end
			pending = due_answers.size();
		end
	end

endmodule

// File: bench/bucketed_fingerprint_table_tb.sv
`timescale 1ns / 1ps

module bucketed_fingerprint_table_tb;

	localparam int HASH_W    = bft_pkg::HASH_W;
	localparam int ID_W      = bft_pkg::ID_W;
	localparam int ROW_SHIFT = bft_pkg::ROW_SHIFT;
	localparam int S_DATA_W  = bft_pkg::S_DATA_W;
	localparam int M_DATA_W  = bft_pkg::M_DATA_W;
	localparam int ROW_W     = bft_pkg::ROW_BITS_DEF;
	localparam int UPPER_W   = HASH_W - ROW_SHIFT - ROW_W;
	localparam int HOLD_AT   = 60;
	localparam int HOLD_LEN  = 400;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                s_tuser  = bft_pkg::MODE_LOOKUP;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int errors;
	int pending;
	int hits;
	int full_rejects;
	int words_sent = 0;
	int words_taken = 0;

	bucketed_fingerprint_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bft_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.errors       (errors),
		.pending      (pending),
		.hits         (hits),
		.full_rejects (full_rejects)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [HASH_W-1:0] hash_at(logic [UPPER_W-1:0] upper,
			logic [ROW_W-1:0] row, logic [ROW_SHIFT-1:0] low);
		return {upper, row, low};
	endfunction

	// gaps drawn per word, with calm stretches of back-to-back words
	task automatic send_word(logic mode, logic [HASH_W-1:0] hash, logic [ID_W-1:0] id);
		int gap;
		gap = ((words_sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {id, hash};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// result side, with one long hold so the block backs up
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if (words_taken == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				stall = ((words_taken / 40) % 3 == 2) ? 0 : $urandom_range(0, 13);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			words_taken++;
		end
	end

	initial begin
		logic [HASH_W-1:0] h;
		logic [HASH_W-1:0] dup_hash;
		logic [HASH_W-1:0] stored[$];
		logic [ROW_W-1:0]  hot_rows[8];
		logic              mode;
		logic [ID_W-1:0]   id;
		int                pick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, zero id, all-ones hash and id
		send_word(bft_pkg::MODE_LOOKUP, '0, 27'h5A5);
		send_word(bft_pkg::MODE_INSERT, '0, '0);
		send_word(bft_pkg::MODE_LOOKUP, '0, '1);
		send_word(bft_pkg::MODE_INSERT, '1, '1);
		send_word(bft_pkg::MODE_LOOKUP, '1, '0);
		// same row and low bits, upper bits differ
		send_word(bft_pkg::MODE_INSERT, hash_at('0, '1, '1), 27'h1234567);
		send_word(bft_pkg::MODE_LOOKUP, hash_at('0, '1, '1), '0);
		send_word(bft_pkg::MODE_LOOKUP, hash_at(14'h2000, '1, '1), '0);
		// duplicates, oldest wins
		dup_hash = hash_at(14'h155, '1, 21'h0AAAA);
		send_word(bft_pkg::MODE_INSERT, dup_hash, 27'd11);
		send_word(bft_pkg::MODE_INSERT, dup_hash, 27'd22);
		send_word(bft_pkg::MODE_LOOKUP, dup_hash, '0);
		// fill the row to the top, then overflow it
		for (int i = 4; i < bft_pkg::ROW_SLOTS_DEF; i++)
			send_word(bft_pkg::MODE_INSERT,
				hash_at(UPPER_W'($urandom), '1, ROW_SHIFT'($urandom)), ID_W'($urandom));
		send_word(bft_pkg::MODE_INSERT, dup_hash, 27'd33);
		send_word(bft_pkg::MODE_LOOKUP, dup_hash, '0);
		send_word(bft_pkg::MODE_LOOKUP, hash_at('0, '1, '0), '0);

		for (int i = 0; i < 900; i++) begin
			if (i % 300 == 0)
				foreach (hot_rows[r])
					hot_rows[r] = ROW_W'($urandom);
			mode = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 9);
			if (mode == bft_pkg::MODE_LOOKUP && stored.size() > 0 && pick < 5) begin
				h = stored[$urandom_range(0, stored.size() - 1)];
				if (pick == 4)
					h[$urandom_range(ROW_SHIFT + ROW_W, HASH_W - 1)] ^= 1'b1;
			end else if (pick < 8) begin
				h = hash_at(UPPER_W'($urandom_range(0, 3)), hot_rows[$urandom_range(0, 7)],
					ROW_SHIFT'($urandom_range(0, 3)));
			end else begin
				h = HASH_W'({$urandom, $urandom});
			end
			id = ($urandom_range(0, 15) == 0) ? '0 : ID_W'($urandom);
			if (mode == bft_pkg::MODE_INSERT) begin
				stored.push_back(h);
				if (stored.size() > 256)
					void'(stored.pop_front());
			end
			send_word(mode, h, id);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d words with random gaps and a long result hold", words_sent);
		$display("lookup hits %0d, inserts refused on full rows %0d", hits, full_rejects);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: bucketed_fingerprint_table.f
src/bft_pkg.sv
src/bft_ram.sv
src/bucketed_fingerprint_table.sv
bench/bft_checker.sv
bench/bucketed_fingerprint_table_tb.sv
